@@ sv/lobs_pkg.sv @@
`timescale 1ns / 1ps
package lobs_pkg;
  localparam int NUM_SYMBOLS = 8;
  localparam int BOOK_DEPTH  = 8;
  localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LVL_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int ENT_W = NUM_SYMBOLS * BOOK_DEPTH;
  localparam int ENT_AW = (ENT_W > 1) ? $clog2(ENT_W) : 1;
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0] CMD_UPSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;
  localparam logic [1:0] SIDE_BID = 2'd0;
  localparam logic [1:0] SIDE_ASK = 2'd1;
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_BUY  = 2'd1;
  localparam logic [1:0] ACT_SELL = 2'd2;
  localparam logic       CFG_THRESH = 1'b0;
  localparam logic       CFG_SPREAD = 1'b1;
  localparam logic [30:0] THRESH_RESET = 31'd500;
  localparam logic [31:0] SPREAD_RESET = 32'd25000;

  typedef enum logic [1:0] {OP_NONE, OP_CLEAR, OP_BID, OP_ASK} op_t;

  // Classified item as held in the queue between front and back.
  typedef struct packed {
    logic [31:0]      tag;
    op_t              op;
    logic             del;
    logic             in_range;
    logic [SYM_W-1:0] sym;
    logic [31:0]      price;
    logic [30:0]      qty;
  } job_t;

  typedef struct packed {
    logic [31:0] tag_out;
    logic [1:0]  action;
    logic [31:0] best_bid_price;
    logic [30:0] best_bid_size;
    logic [31:0] best_ask_price;
    logic [30:0] best_ask_size;
    logic [31:0] spread;
    logic signed [31:0] imbalance;
  } res_t;
endpackage

@@ sv/lobs_if.sv @@
`timescale 1ns / 1ps
interface lobs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] tag;
  logic [1:0]  cmd;
  logic [7:0]  symbol;
  logic [1:0]  side;
  logic [31:0] price;
  logic [30:0] qty;
  modport source (output valid, tag, cmd, symbol, side, price, qty, input ready);
  modport sink (input valid, tag, cmd, symbol, side, price, qty, output ready);
endinterface

interface lobs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] tag_out;
  logic [1:0]  action;
  logic [31:0] best_bid_price;
  logic [30:0] best_bid_size;
  logic [31:0] best_ask_price;
  logic [30:0] best_ask_size;
  logic [31:0] spread;
  logic signed [31:0] imbalance;
  modport source (output valid, tag_out, action, best_bid_price, best_bid_size,
                  best_ask_price, best_ask_size, spread, imbalance, input ready);
  modport sink (input valid, tag_out, action, best_bid_price, best_bid_size,
                best_ask_price, best_ask_size, spread, imbalance, output ready);
endinterface

@@ sv/lobs_front.sv @@
`timescale 1ns / 1ps
module lobs_front
  import lobs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lobs_in_if.sink in,
  output job_t job_o,
  output logic job_valid_o,
  input  logic job_ready_i
);
  job_t             q_r [FIFO_DEPTH];
  logic [0:0]       wp_r, rp_r;
  logic [1:0]       cnt_r;
  job_t             job;
  logic             push, pop;

  always_comb begin
    job.tag      = in.tag;
    job.del      = (in.cmd == CMD_DELETE);
    job.in_range = ({24'd0, in.symbol} < 32'(NUM_SYMBOLS));
    job.sym      = in.symbol[SYM_W-1:0];
    job.price    = in.price;
    job.qty      = in.qty;
    if (in.cmd == CMD_RESET) job.op = OP_CLEAR;
    else if (in.cmd inside {CMD_UPSERT, CMD_DELETE} && in.side == SIDE_BID) job.op = OP_BID;
    else if (in.cmd inside {CMD_UPSERT, CMD_DELETE} && in.side == SIDE_ASK) job.op = OP_ASK;
    else job.op = OP_NONE;
    if (!job.in_range) job.op = OP_NONE;
  end

  assign in.ready   = (cnt_r != 2'(FIFO_DEPTH));
  assign push       = in.valid && in.ready;
  assign job_valid_o = (cnt_r != 2'd0);
  assign job_o      = q_r[rp_r];
  assign pop        = job_valid_o && job_ready_i;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ sv/lobs_back.sv @@
`timescale 1ns / 1ps
module lobs_back
  import lobs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  job_t job_i,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  logic [30:0] thresh_i,
  input  logic [31:0] max_spread_i,
  lobs_out_if.source out
);
  typedef logic [31:0] prow_t [BOOK_DEPTH];
  typedef logic [30:0] qrow_t [BOOK_DEPTH];
  typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} st_t;

  // Book rows, one per symbol; valid bits stand in for the reset clear.
  logic [31:0] bp_mem [NUM_SYMBOLS][BOOK_DEPTH];
  logic [30:0] bq_mem [NUM_SYMBOLS][BOOK_DEPTH];
  logic [31:0] ap_mem [NUM_SYMBOLS][BOOK_DEPTH];
  logic [30:0] aq_mem [NUM_SYMBOLS][BOOK_DEPTH];
  logic [NUM_SYMBOLS-1:0] vld_r;

  st_t   st_r;
  job_t  job_r;
  prow_t bp_r, ap_r;
  qrow_t bq_r, aq_r;
  res_t  res_r;
  logic  ovalid_r;

  prow_t np, bp_n, ap_n;
  qrow_t nq, bq_n, aq_n;
  res_t  res_n;
  logic  allow, desc;
  logic  fire;
  logic signed [32:0] imb;
  logic [31:0] spr;

  function automatic void upd(input prow_t px, input qrow_t qt, input logic [31:0] price,
                              input logic [30:0] qty, input logic del, input logic dsc,
                              output prow_t opx, output qrow_t oqt);
    logic hit;
    logic [LVL_W-1:0] h;
    logic fnd;
    logic [LVL_W-1:0] pos;
    logic rm;
    hit = 1'b0; h = '0; fnd = 1'b0; pos = '0;
    opx = px; oqt = qt;
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (qt[i] != 31'd0 && px[i] == price) begin hit = 1'b1; h = LVL_W'(i); end
    rm = del || (qty == 31'd0);
    if (hit) begin
      if (rm) begin
        for (int i = 0; i < BOOK_DEPTH; i++)
          if (LVL_W'(i) >= h) begin
            if (i + 1 < BOOK_DEPTH) begin opx[i] = px[i+1]; oqt[i] = qt[i+1]; end
            else begin opx[i] = '0; oqt[i] = '0; end
          end
      end else oqt[h] = qty;
    end else if (!rm) begin
      for (int i = BOOK_DEPTH - 1; i >= 0; i--)
        if (qt[i] == 31'd0 || (dsc ? price > px[i] : price < px[i])) begin
          fnd = 1'b1; pos = LVL_W'(i);
        end
      if (fnd)
        for (int i = 0; i < BOOK_DEPTH; i++)
          if (LVL_W'(i) == pos) begin opx[i] = price; oqt[i] = qty; end
          else if (LVL_W'(i) > pos) begin opx[i] = px[i-1]; oqt[i] = qt[i-1]; end
    end
  endfunction

  always_comb begin
    bp_n = bp_r; bq_n = bq_r; ap_n = ap_r; aq_n = aq_r;
    desc = (job_r.op == OP_BID);
    allow = job_r.del || (desc ? (aq_r[0] == 31'd0 || job_r.price < ap_r[0])
                               : (bq_r[0] == 31'd0 || job_r.price > bp_r[0]));
    upd(desc ? bp_r : ap_r, desc ? bq_r : aq_r, job_r.price, job_r.qty, job_r.del, desc,
        np, nq);
    case (job_r.op)
      OP_CLEAR: begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
          bp_n[i] = '0; bq_n[i] = '0; ap_n[i] = '0; aq_n[i] = '0;
        end
      end
      OP_BID: if (allow) begin bp_n = np; bq_n = nq; end
      OP_ASK: if (allow) begin ap_n = np; aq_n = nq; end
      default: ;
    endcase
    imb = 33'($signed({2'b00, bq_n[0]})) - 33'($signed({2'b00, aq_n[0]}));
    spr = ap_n[0] - bp_n[0];
    res_n = '0;
    res_n.tag_out = job_r.tag;
    if (job_r.in_range) begin
      res_n.best_bid_price = bp_n[0];
      res_n.best_bid_size  = bq_n[0];
      res_n.best_ask_price = ap_n[0];
      res_n.best_ask_size  = aq_n[0];
      res_n.imbalance      = imb[31:0];
      if (bq_n[0] != 31'd0 && aq_n[0] != 31'd0 && ap_n[0] > bp_n[0]) begin
        res_n.spread = spr;
        if (spr <= max_spread_i) begin
          if (imb >= $signed({2'b00, thresh_i})) res_n.action = ACT_BUY;
          else if (imb <= -$signed({2'b00, thresh_i})) res_n.action = ACT_SELL;
        end
      end
    end
  end

  // The update step waits until the output register is free or being emptied.
  assign fire = (st_r == S_OUT) && (!ovalid_r || out.ready);

  assign job_ready_o = (st_r == S_IDLE);
  assign out.valid = ovalid_r;
  assign out.tag_out = res_r.tag_out;
  assign out.action = res_r.action;
  assign out.best_bid_price = res_r.best_bid_price;
  assign out.best_bid_size = res_r.best_bid_size;
  assign out.best_ask_price = res_r.best_ask_price;
  assign out.best_ask_size = res_r.best_ask_size;
  assign out.spread = res_r.spread;
  assign out.imbalance = res_r.imbalance;

  always_ff @(posedge clk) begin
    if (job_valid_i && job_ready_o) job_r <= job_i;
    if (st_r == S_READ) begin
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        bp_r[i] <= vld_r[job_r.sym] ? bp_mem[job_r.sym][i] : '0;
        bq_r[i] <= vld_r[job_r.sym] ? bq_mem[job_r.sym][i] : '0;
        ap_r[i] <= vld_r[job_r.sym] ? ap_mem[job_r.sym][i] : '0;
        aq_r[i] <= vld_r[job_r.sym] ? aq_mem[job_r.sym][i] : '0;
      end
    end
    if (fire) begin
      res_r <= res_n;
      if (job_r.in_range)
        for (int i = 0; i < BOOK_DEPTH; i++) begin
          bp_mem[job_r.sym][i] <= bp_n[i]; bq_mem[job_r.sym][i] <= bq_n[i];
          ap_mem[job_r.sym][i] <= ap_n[i]; aq_mem[job_r.sym][i] <= aq_n[i];
        end
    end
    if (!rst_n) begin
      st_r <= S_IDLE; ovalid_r <= 1'b0; vld_r <= '0;
    end else begin
      if (fire) ovalid_r <= 1'b1;
      else if (out.ready) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (job_valid_i) st_r <= S_READ;
        S_READ: st_r <= S_OUT;
        S_OUT: begin
          if (fire) begin
            if (job_r.in_range) vld_r[job_r.sym] <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/limit_order_book_signal.sv @@
`timescale 1ns / 1ps
// An accepted item passes through the queue, the read of its symbol's book row, the update
// and the output register before its result is offered.
// The back end takes a new item only once the read-update-write of the last item's row is done.
// A waiting result holds the back end in its update step; the two-entry queue takes items meanwhile.
// Reset (synchronous, active low) empties every book and loads the register defaults.
module limit_order_book_signal
  import lobs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lobs_in_if.sink in,
  lobs_out_if.source out,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  job_t        job;
  logic        job_valid, job_ready;
  logic [30:0] thresh_r;
  logic [31:0] spread_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET; spread_r <= SPREAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESH: thresh_r <= cfg_data[30:0];
        CFG_SPREAD: spread_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lobs_front u_front (.clk, .rst_n, .in, .job_o(job), .job_valid_o(job_valid),
                      .job_ready_i(job_ready));
  lobs_back u_back (.clk, .rst_n, .job_i(job), .job_valid_i(job_valid),
                    .job_ready_o(job_ready), .thresh_i(thresh_r),
                    .max_spread_i(spread_r), .out);
endmodule

@@ dv/lobs_tb_if.sv @@
`timescale 1ns / 1ps
// The block's own channel interfaces come with the RTL; this file only holds
// the item types that the test tasks share.
package lobs_tb_types_pkg;
  typedef struct {
    logic [31:0] tag;
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic [1:0]  side;
    logic [31:0] price;
    logic [30:0] qty;
  } book_event_t;
endpackage

@@ dv/limit_order_book_signal_tb.sv @@
`timescale 1ns / 1ps
module limit_order_book_signal_tb;
  import lobs_pkg::*;
  import lobs_tb_types_pkg::*;

  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam logic [1:0] SIDE_NONE  = 2'd2;
  localparam logic [1:0] SIDE_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;

  lobs_in_if  in_ch();
  lobs_out_if out_ch();

  limit_order_book_signal u_dut (
    .clk(clk), .rst_n(rst_n), .in(in_ch.sink), .out(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted book, threshold and spread limit.
  logic [31:0] bid_px [NUM_SYMBOLS][BOOK_DEPTH];
  logic [30:0] bid_qt [NUM_SYMBOLS][BOOK_DEPTH];
  logic [31:0] ask_px [NUM_SYMBOLS][BOOK_DEPTH];
  logic [30:0] ask_qt [NUM_SYMBOLS][BOOK_DEPTH];
  logic [30:0] thresh;
  logic [31:0] spread_lim;

  res_t expected_tops[$];
  int   mismatches;
  int   idle_cycles;
  bit   rx_hold;
  int   seq;

  function automatic void update_side(ref logic [31:0] px [BOOK_DEPTH],
                                      ref logic [30:0] qt [BOOK_DEPTH],
                                      input logic [31:0] price,
                                      input logic [30:0] qty, input bit del,
                                      input bit descending);
    int hit;
    int pos;
    hit = -1;
    pos = -1;
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (qt[i] != 0 && px[i] == price) hit = i;
    if (hit >= 0) begin
      if (del || qty == 0) begin
        for (int i = hit; i + 1 < BOOK_DEPTH; i++) begin
          px[i] = px[i + 1];
          qt[i] = qt[i + 1];
        end
        px[BOOK_DEPTH - 1] = '0;
        qt[BOOK_DEPTH - 1] = '0;
      end else begin
        qt[hit] = qty;
      end
      return;
    end
    if (del || qty == 0) return;
    for (int i = 0; i < BOOK_DEPTH; i++)
      if (qt[i] == 0 || (descending ? price > px[i] : price < px[i])) begin
        pos = i;
        break;
      end
    if (pos < 0) return;
    for (int i = BOOK_DEPTH - 1; i > pos; i--) begin
      px[i] = px[i - 1];
      qt[i] = qt[i - 1];
    end
    px[pos] = price;
    qt[pos] = qty;
  endfunction

  function automatic res_t apply_event(book_event_t ev);
    res_t r;
    int s;
    bit del;
    longint imb;
    r = '0;
    r.tag_out = ev.tag;
    if (ev.symbol < NUM_SYMBOLS) begin
      s = int'(ev.symbol);
      del = (ev.cmd == CMD_DELETE);
      if (ev.cmd == CMD_RESET) begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
          bid_px[s][i] = '0; bid_qt[s][i] = '0;
          ask_px[s][i] = '0; ask_qt[s][i] = '0;
        end
      end else if (ev.cmd <= CMD_DELETE && ev.side == SIDE_BID) begin
        if (del || ask_qt[s][0] == 0 || ev.price < ask_px[s][0])
          update_side(bid_px[s], bid_qt[s], ev.price, ev.qty, del, 1'b1);
      end else if (ev.cmd <= CMD_DELETE && ev.side == SIDE_ASK) begin
        if (del || bid_qt[s][0] == 0 || ev.price > bid_px[s][0])
          update_side(ask_px[s], ask_qt[s], ev.price, ev.qty, del, 1'b0);
      end
      r.best_bid_price = bid_px[s][0];
      r.best_bid_size  = bid_qt[s][0];
      r.best_ask_price = ask_px[s][0];
      r.best_ask_size  = ask_qt[s][0];
      imb = longint'(bid_qt[s][0]) - longint'(ask_qt[s][0]);
      r.imbalance = imb[31:0];
      r.action = ACT_NONE;
      if (bid_qt[s][0] != 0 && ask_qt[s][0] != 0 && ask_px[s][0] > bid_px[s][0]) begin
        r.spread = ask_px[s][0] - bid_px[s][0];
        if (r.spread <= spread_lim) begin
          if (imb >= longint'(thresh)) r.action = ACT_BUY;
          else if (imb <= -longint'(thresh)) r.action = ACT_SELL;
        end
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Valid stays high after an item is taken; the next item or a gap decides what follows.
  task automatic send_event(book_event_t ev, bit with_gaps = 1'b1);
    int g;
    g = with_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.tag    <= ev.tag;
    in_ch.cmd    <= ev.cmd;
    in_ch.symbol <= ev.symbol;
    in_ch.side   <= ev.side;
    in_ch.price  <= ev.price;
    in_ch.qty    <= ev.qty;
    do @(posedge clk); while (!in_ch.ready);
    expected_tops = {expected_tops, apply_event(ev)};
  endtask

  function automatic book_event_t build_event(logic [1:0] cmd, logic [7:0] sym,
                                              logic [1:0] side, logic [31:0] price,
                                              logic [30:0] qty);
    book_event_t ev;
    ev.tag = {16'($urandom_range(0, 65535)), 16'(seq)};
    seq++;
    ev.cmd = cmd; ev.symbol = sym; ev.side = side; ev.price = price; ev.qty = qty;
    return ev;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_tops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESH) thresh = val[30:0];
    else spread_lim = val;
  endtask

  task automatic test_directed();
    logic [30:0] qmax;
    qmax = 31'h7FFF_FFFF;
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_BID, 32'd1000, 31'd700));
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_ASK, 32'd1100, 31'd100));
    // A bid at the best ask and an ask at the best bid are both dropped.
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_BID, 32'd1100, 31'd5));
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_ASK, 32'd1000, 31'd5));
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_ASK, 32'd1100, 31'd900));
    for (int i = 0; i < BOOK_DEPTH + 1; i++)
      send_event(build_event(CMD_UPSERT, 8'd0, SIDE_BID, 32'(900 - 10 * i), 31'(1 + i)));
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_BID, 32'd950, 31'd3));
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_BID, 32'd1000, 31'd0));
    send_event(build_event(CMD_DELETE, 8'd0, SIDE_BID, 32'd950, qmax));
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_NONE, 32'd5, 31'd5));
    send_event(build_event(CMD_UPSERT, 8'd0, SIDE_SPARE, 32'd5, 31'd5));
    send_event(build_event(CMD_SPARE, 8'd0, SIDE_BID, 32'd5, 31'd5));
    send_event(build_event(CMD_UPSERT, 8'hFF, SIDE_BID, 32'd5, 31'd5));
    send_event(build_event(CMD_UPSERT, 8'd1, SIDE_BID, 32'd0, qmax));
    send_event(build_event(CMD_UPSERT, 8'd1, SIDE_ASK, 32'hFFFF_FFFF, qmax));
    send_event(build_event(CMD_RESET, 8'd0, SIDE_BID, 32'd0, 31'd0));
  endtask

  task automatic test_random(int n);
    book_event_t ev;
    int p;
    logic [31:0] mid;
    logic [30:0] q;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      mid = 32'd100000 + $urandom_range(0, 4) * 20;
      q = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 2000));
      if (p < 85) begin
        ev = build_event(($urandom_range(0, 5) == 0) ? CMD_DELETE : CMD_UPSERT,
                         8'($urandom_range(0, NUM_SYMBOLS - 1)), 2'($urandom_range(0, 1)),
                         mid + $urandom_range(0, 300) - 150, q);
      end else if (p < 88) begin
        ev = build_event(CMD_RESET, 8'($urandom_range(0, NUM_SYMBOLS - 1)),
                         2'($urandom_range(0, 3)), $urandom, 31'($urandom));
      end else begin
        ev = build_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         2'($urandom_range(0, 3)), $urandom, 31'($urandom));
      end
      send_event(ev);
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    for (int k = 0; k < 12; k++)
      send_event(build_event(CMD_UPSERT, 8'($urandom_range(0, NUM_SYMBOLS - 1)),
                             2'($urandom_range(0, 1)), 32'd100000 + $urandom_range(0, 99),
                             31'($urandom_range(1, 900))), 1'b0);
  endtask

  task automatic test_config();
    write_reg(CFG_THRESH, 32'd0);
    write_reg(CFG_SPREAD, 32'hFFFF_FFFF);
    test_random(300);
    write_reg(CFG_THRESH, 32'h7FFF_FFFF);
    write_reg(CFG_SPREAD, 32'd0);
    test_random(150);
    write_reg(CFG_THRESH, 32'd1500);
    write_reg(CFG_SPREAD, 32'd40);
    test_random(300);
  endtask

  // Result side: random stalls, plus a long hold while rx_hold is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50);
    end
  end

  initial begin
    rx_hold = 1'b0;
    forever begin
      wait (rx_hold);
      repeat (200) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result tag=%h", out_ch.tag_out);
      end else begin
        exp_r = expected_tops.pop_front();
        if (out_ch.tag_out !== exp_r.tag_out || out_ch.action !== exp_r.action ||
            out_ch.best_bid_price !== exp_r.best_bid_price ||
            out_ch.best_bid_size !== exp_r.best_bid_size ||
            out_ch.best_ask_price !== exp_r.best_ask_price ||
            out_ch.best_ask_size !== exp_r.best_ask_size ||
            out_ch.spread !== exp_r.spread || out_ch.imbalance !== exp_r.imbalance) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp tag=%h act=%0d bid=%0d/%0d ask=%0d/%0d spr=%0d imb=%0d",
                     exp_r.tag_out, exp_r.action, exp_r.best_bid_price,
                     exp_r.best_bid_size, exp_r.best_ask_price, exp_r.best_ask_size,
                     exp_r.spread, exp_r.imbalance);
            $display("         got tag=%h act=%0d bid=%0d/%0d ask=%0d/%0d spr=%0d imb=%0d",
                     out_ch.tag_out, out_ch.action,
                     out_ch.best_bid_price, out_ch.best_bid_size,
                     out_ch.best_ask_price, out_ch.best_ask_size,
                     out_ch.spread, out_ch.imbalance);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("[limit_order_book_signal] ERROR");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    seq = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.tag = '0; in_ch.cmd = '0; in_ch.symbol = '0;
    in_ch.side = '0; in_ch.price = '0; in_ch.qty = '0;
    thresh = THRESH_RESET;
    spread_lim = SPREAD_RESET;
    for (int s = 0; s < NUM_SYMBOLS; s++)
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        bid_px[s][i] = '0; bid_qt[s][i] = '0;
        ask_px[s][i] = '0; ask_qt[s][i] = '0;
      end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    drain();
    test_config();
    test_random(580);
    drain();
    if (mismatches == 0) begin
      $display("[limit_order_book_signal] OK");
    end else begin
      $display("[limit_order_book_signal] ERROR");
    end
    $finish;
  end
endmodule
